// File: src/isotp_pkg.sv
// Shared types, constants and byte helpers for the ISO-TP receive reassembler.
// No dependencies; used by isotp_ctrl, isotp_dp and the top level.
package isotp_pkg;

    localparam int PAIRS        = 4;
    localparam int BUFFER_BYTES = 256;

    localparam int PAIR_W    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int BUF_AW    = $clog2(BUFFER_BYTES);
    localparam int CNT_W     = $clog2(BUFFER_BYTES + 1);
    localparam int RAM_AW    = PAIR_W + BUF_AW;
    localparam int RAM_DEPTH = 1 << RAM_AW;

    localparam logic [31:0] ID_MASK      = 32'h9FFF_FFFF;
    localparam int          EXT_ADDR_BIT = 30;
    localparam int          PAD_BIT      = 29;
    localparam logic [7:0]  PCI_FC_CTS   = 8'h30;
    localparam logic [7:0]  PCI_FF_BYTE  = 8'h10;
    localparam logic [3:0]  FF_HEAD      = 4'd10;

    localparam logic [3:0] PCI_SF = 4'h0;
    localparam logic [3:0] PCI_FF = 4'h1;
    localparam logic [3:0] PCI_CF = 4'h2;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_FRAME = 2'd2;

    localparam logic [1:0] KIND_CHUNK = 2'd0;
    localparam logic [1:0] KIND_FC    = 2'd1;
    localparam logic [1:0] KIND_FWD   = 2'd2;

    localparam logic CFG_BLOCK_SIZE = 1'b0;
    localparam logic CFG_SEP_TIME   = 1'b1;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_FWD,
        ACT_SF,
        ACT_FF,
        ACT_CF,
        ACT_CF_DONE
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WR,
        ST_RES_OUT,
        ST_SF_OUT,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_CHUNK_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic decode;
        logic wr;
        logic sf_next;
        logic capture;
        logic chunk_next;
    } ctrl_cmd_t;

    typedef struct packed {
        action_t action;
        logic    wr_last;
        logic    mode_ff;
        logic    cf_done;
        logic    chunk_full;
        logic    out_last;
    } dp_stat_t;

    function automatic logic [7:0] byte_at(input logic [63:0] d, input logic [2:0] k);
        byte_at = d[8*(7-k) +: 8];
    endfunction

    function automatic logic [7:0] id_byte(input logic [31:0] id, input logic [1:0] k);
        id_byte = id[8*(3-k) +: 8];
    endfunction

endpackage

// File: src/isotp_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module isotp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/isotp_ctrl.sv
// Sequencer for the reassembler: accepts items, steps buffer writes and chunk reads.
// Depends on isotp_pkg; drives isotp_dp through ctrl_cmd_t.
module isotp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic [1:0]            s_command,
    input  logic                  m_ready,
    input  isotp_pkg::dp_stat_t   st,
    output logic                  s_ready,
    output logic                  m_valid,
    output isotp_pkg::ctrl_cmd_t  cmd
);

    isotp_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= isotp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            isotp_pkg::ST_IDLE: begin
                if (s_valid && s_command == isotp_pkg::CMD_FRAME) begin
                    state_next = isotp_pkg::ST_DECODE;
                end
            end
            isotp_pkg::ST_DECODE: begin
                case (st.action)
                    isotp_pkg::ACT_FWD: state_next = isotp_pkg::ST_RES_OUT;
                    isotp_pkg::ACT_SF:  state_next = isotp_pkg::ST_SF_OUT;
                    isotp_pkg::ACT_FF, isotp_pkg::ACT_CF, isotp_pkg::ACT_CF_DONE:
                        state_next = isotp_pkg::ST_WR;
                    default: state_next = isotp_pkg::ST_IDLE;
                endcase
            end
            isotp_pkg::ST_WR: begin
                if (st.wr_last) begin
                    if (st.mode_ff) begin
                        state_next = isotp_pkg::ST_RES_OUT;
                    end else if (st.cf_done) begin
                        state_next = isotp_pkg::ST_RD_ADDR;
                    end else begin
                        state_next = isotp_pkg::ST_IDLE;
                    end
                end
            end
            isotp_pkg::ST_RES_OUT: begin
                if (m_ready) begin
                    state_next = isotp_pkg::ST_IDLE;
                end
            end
            isotp_pkg::ST_SF_OUT: begin
                if (m_ready && st.out_last) begin
                    state_next = isotp_pkg::ST_IDLE;
                end
            end
            isotp_pkg::ST_RD_ADDR: begin
                state_next = isotp_pkg::ST_RD_DATA;
            end
            isotp_pkg::ST_RD_DATA: begin
                state_next = st.chunk_full ? isotp_pkg::ST_CHUNK_OUT : isotp_pkg::ST_RD_ADDR;
            end
            isotp_pkg::ST_CHUNK_OUT: begin
                if (m_ready) begin
                    state_next = st.out_last ? isotp_pkg::ST_IDLE : isotp_pkg::ST_RD_ADDR;
                end
            end
            default: state_next = isotp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        cmd     = '0;
        case (state_reg)
            isotp_pkg::ST_IDLE: begin
                s_ready    = aresetn;
                cmd.accept = s_valid && aresetn;
            end
            isotp_pkg::ST_DECODE: cmd.decode = 1'b1;
            isotp_pkg::ST_WR:     cmd.wr = 1'b1;
            isotp_pkg::ST_RES_OUT: m_valid = 1'b1;
            isotp_pkg::ST_SF_OUT: begin
                m_valid     = 1'b1;
                cmd.sf_next = m_ready && !st.out_last;
            end
            isotp_pkg::ST_RD_ADDR: ;
            isotp_pkg::ST_RD_DATA: cmd.capture = 1'b1;
            isotp_pkg::ST_CHUNK_OUT: begin
                m_valid        = 1'b1;
                cmd.chunk_next = m_ready && !st.out_last;
            end
            default: ;
        endcase
    end

endmodule

// File: src/isotp_dp.sv
// Datapath: address pair table, per-pair reassembly state, frame decode,
// buffer RAM and the result register. Depends on isotp_pkg and isotp_ram.
module isotp_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  isotp_pkg::ctrl_cmd_t cmd,
    output isotp_pkg::dp_stat_t  st,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_wdata,
    input  logic [1:0]           s_command,
    input  logic [1:0]           s_pair_index,
    input  logic [31:0]          s_pair_tx_id,
    input  logic [7:0]           s_pair_tx_ext,
    input  logic [7:0]           s_pair_tx_pad,
    input  logic [31:0]          s_pair_rx_id,
    input  logic [7:0]           s_pair_rx_ext,
    input  logic [7:0]           s_pair_channel,
    input  logic [31:0]          s_frame_id,
    input  logic [3:0]           s_frame_dlc,
    input  logic [63:0]          s_frame_data,
    output logic [1:0]           m_kind,
    output logic [7:0]           m_channel,
    output logic [31:0]          m_out_id,
    output logic [3:0]           m_out_length,
    output logic [63:0]          m_out_data,
    output logic                 m_last
);

    localparam int PN = isotp_pkg::PAIRS;
    localparam int PW = isotp_pkg::PAIR_W;
    localparam int AW = isotp_pkg::BUF_AW;
    localparam int CW = isotp_pkg::CNT_W;

    logic [7:0] bs_reg, stmin_reg;

    logic        valid_reg [PN];
    logic [31:0] tx_id_reg [PN];
    logic [7:0]  tx_ext_reg [PN];
    logic [7:0]  tx_pad_reg [PN];
    logic [31:0] rx_id_reg [PN];
    logic [7:0]  rx_ext_reg [PN];
    logic [7:0]  chan_reg [PN];

    logic [CW-1:0] fill_reg [PN];
    logic [CW-1:0] msize_reg [PN];
    logic [3:0]    seq_reg [PN];

    logic [31:0] frm_id_reg;
    logic [3:0]  frm_dlc_reg;
    logic [63:0] frm_data_reg;

    logic [PW-1:0] hit_reg;
    logic          pci_reg;
    logic          mode_ff_reg;
    logic          cf_done_reg;
    logic [3:0]    len_reg;
    logic [AW-1:0] wbase_reg;
    logic [3:0]    nbytes_reg;
    logic [3:0]    j_reg;
    logic [CW-1:0] size_reg;
    logic [CW-1:0] pos_reg;
    logic [2:0]    k_reg;

    logic [1:0]  kind_reg;
    logic [7:0]  chan_out_reg;
    logic [31:0] id_out_reg;
    logic [3:0]  olen_reg;
    logic [63:0] odata_reg;
    logic        olast_reg;

    // decode
    logic          found;
    logic [PW-1:0] hit_idx;
    logic          pci;
    logic [7:0]    pb;
    logic [7:0]    ff_len;
    logic [9:0]    ff_size;
    logic          ok_sf, ok_ff, ok_cf;
    logic [3:0]    sf_total;
    logic [CW-1:0] cf_off, cf_size, cf_rem, cf_cap;
    logic [3:0]    cf_n;
    logic          cf_done;
    isotp_pkg::action_t action;

    // single frame message
    logic          use_pci;
    logic [3:0]    use_t;
    logic [7:0]    msg [12];
    logic [63:0]   sf_chunk0, sf_chunk1;

    // flow control
    logic [7:0]    fc [9];
    logic [31:0]   fc_txid;
    logic [3:0]    fc_start;
    logic [3:0]    fc_dlc;
    logic [63:0]   fc_data;

    logic [7:0]    wr_byte;
    logic          wr_last;
    logic [isotp_pkg::RAM_AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_rdata;
    logic          pos_end;

    always_comb begin
        found   = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < PN; i++) begin
            if (!found && valid_reg[i]
                && (frm_id_reg & isotp_pkg::ID_MASK) == (rx_id_reg[i] & isotp_pkg::ID_MASK)
                && (!rx_id_reg[i][isotp_pkg::EXT_ADDR_BIT]
                    || rx_ext_reg[i] == isotp_pkg::byte_at(frm_data_reg, 3'd0))) begin
                found   = 1'b1;
                hit_idx = PW'(i);
            end
        end
    end

    always_comb begin
        pci      = rx_id_reg[hit_idx][isotp_pkg::EXT_ADDR_BIT];
        pb       = isotp_pkg::byte_at(frm_data_reg, {2'b0, pci});
        ff_len   = isotp_pkg::byte_at(frm_data_reg, pci ? 3'd2 : 3'd1);
        ff_size  = {2'b0, ff_len} + {9'b0, pci} + 10'd4;
        sf_total = {1'b0, pb[2:0]} + {3'b0, pci} + 4'd4;
        ok_sf    = pb <= (8'd7 - {7'b0, pci});
        ok_ff    = pb == isotp_pkg::PCI_FF_BYTE && ff_size <= 10'(isotp_pkg::BUFFER_BYTES);
        cf_off   = fill_reg[hit_idx];
        cf_size  = msize_reg[hit_idx];
        ok_cf    = cf_off < cf_size && pb[3:0] == seq_reg[hit_idx];
        cf_rem   = cf_size - cf_off;
        cf_cap   = CW'(3'd7 - {2'b0, pci});
        cf_n     = (cf_rem < cf_cap) ? cf_rem[3:0] : cf_cap[3:0];
        cf_done  = cf_rem <= cf_cap;
        action   = isotp_pkg::ACT_NONE;
        if (!found) begin
            action = isotp_pkg::ACT_FWD;
        end else begin
            case (pb[7:4])
                isotp_pkg::PCI_SF: if (ok_sf) action = isotp_pkg::ACT_SF;
                isotp_pkg::PCI_FF: if (ok_ff) action = isotp_pkg::ACT_FF;
                isotp_pkg::PCI_CF: begin
                    if (ok_cf) begin
                        action = cf_done ? isotp_pkg::ACT_CF_DONE : isotp_pkg::ACT_CF;
                    end
                end
                default: action = isotp_pkg::ACT_NONE;
            endcase
        end
    end

    always_comb begin
        use_pci = cmd.decode ? pci : pci_reg;
        use_t   = cmd.decode ? sf_total : len_reg;
        for (int p = 0; p < 12; p++) begin
            if (p < 4) begin
                msg[p] = isotp_pkg::id_byte(frm_id_reg, 2'(p));
            end else if (p == 4) begin
                msg[p] = isotp_pkg::byte_at(frm_data_reg, use_pci ? 3'd0 : 3'd1);
            end else begin
                msg[p] = isotp_pkg::byte_at(frm_data_reg, 3'(p - 3));
            end
            if (4'(p) >= use_t) begin
                msg[p] = 8'h00;
            end
        end
        sf_chunk0 = {msg[0], msg[1], msg[2], msg[3], msg[4], msg[5], msg[6], msg[7]};
        sf_chunk1 = {msg[8], msg[9], msg[10], msg[11], 32'h0};
    end

    always_comb begin
        fc_txid = tx_id_reg[hit_reg];
        fc[0]   = tx_ext_reg[hit_reg];
        fc[1]   = isotp_pkg::PCI_FC_CTS;
        fc[2]   = bs_reg;
        fc[3]   = stmin_reg;
        for (int q = 4; q < 9; q++) begin
            fc[q] = tx_pad_reg[hit_reg];
        end
        fc_start = fc_txid[isotp_pkg::EXT_ADDR_BIT] ? 4'd0 : 4'd1;
        fc_dlc   = fc_txid[isotp_pkg::PAD_BIT] ? 4'd8
                 : (fc_txid[isotp_pkg::EXT_ADDR_BIT] ? 4'd4 : 4'd3);
        for (int k = 0; k < 8; k++) begin
            fc_data[8*(7-k) +: 8] = (4'(k) < fc_dlc) ? fc[fc_start + 4'(k)] : 8'h00;
        end
    end

    always_comb begin
        if (mode_ff_reg) begin
            if (j_reg < 4'd4) begin
                wr_byte = isotp_pkg::id_byte(frm_id_reg, j_reg[1:0]);
            end else if (j_reg == 4'd4 && pci_reg) begin
                wr_byte = isotp_pkg::byte_at(frm_data_reg, 3'd0);
            end else begin
                wr_byte = isotp_pkg::byte_at(frm_data_reg, 3'(j_reg - 4'd2));
            end
        end else begin
            wr_byte = isotp_pkg::byte_at(frm_data_reg, 3'({3'b0, pci_reg} + 4'd1 + j_reg));
        end
        wr_last   = j_reg == nbytes_reg - 4'd1;
        ram_waddr = {hit_reg, AW'(wbase_reg + AW'(j_reg))};
        ram_raddr = {hit_reg, pos_reg[AW-1:0]};
        pos_end   = pos_reg + CW'(1) == size_reg;
    end

    isotp_ram #(
        .WIDTH(8),
        .DEPTH(isotp_pkg::RAM_DEPTH)
    ) u_buf (
        .aclk  (aclk),
        .we    (cmd.wr),
        .waddr (ram_waddr),
        .wdata (wr_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // configuration, pair table and per-pair reassembly state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bs_reg    <= '0;
            stmin_reg <= '0;
            for (int i = 0; i < PN; i++) begin
                valid_reg[i] <= 1'b0;
                fill_reg[i]  <= '0;
                msize_reg[i] <= '0;
                seq_reg[i]   <= '0;
            end
        end else begin
            if (cfg_we) begin
                if (cfg_index == isotp_pkg::CFG_BLOCK_SIZE) begin
                    bs_reg <= cfg_wdata;
                end else begin
                    stmin_reg <= cfg_wdata;
                end
            end
            if (cmd.accept) begin
                for (int i = 0; i < PN; i++) begin
                    if (s_command == isotp_pkg::CMD_CLEAR) begin
                        valid_reg[i] <= 1'b0;
                    end else if (s_command == isotp_pkg::CMD_LOAD
                                 && 32'(s_pair_index) == i) begin
                        valid_reg[i] <= 1'b1;
                    end
                end
            end
            if (cmd.decode) begin
                if (action == isotp_pkg::ACT_FF) begin
                    fill_reg[hit_idx]  <= CW'(isotp_pkg::FF_HEAD);
                    msize_reg[hit_idx] <= CW'(ff_size);
                    seq_reg[hit_idx]   <= 4'd1;
                end else if (action == isotp_pkg::ACT_CF || action == isotp_pkg::ACT_CF_DONE) begin
                    fill_reg[hit_idx] <= cf_off + CW'(cf_n);
                    seq_reg[hit_idx]  <= seq_reg[hit_idx] + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && s_command == isotp_pkg::CMD_LOAD) begin
            for (int i = 0; i < PN; i++) begin
                if (32'(s_pair_index) == i) begin
                    tx_id_reg[i]  <= s_pair_tx_id;
                    tx_ext_reg[i] <= s_pair_tx_ext;
                    tx_pad_reg[i] <= s_pair_tx_pad;
                    rx_id_reg[i]  <= s_pair_rx_id;
                    rx_ext_reg[i] <= s_pair_rx_ext;
                    chan_reg[i]   <= s_pair_channel;
                end
            end
        end
        if (cmd.accept && s_command == isotp_pkg::CMD_FRAME) begin
            frm_id_reg   <= s_frame_id;
            frm_dlc_reg  <= s_frame_dlc;
            frm_data_reg <= s_frame_data;
        end
        if (cmd.decode) begin
            hit_reg     <= hit_idx;
            pci_reg     <= pci;
            len_reg     <= sf_total;
            j_reg       <= '0;
            mode_ff_reg <= action == isotp_pkg::ACT_FF;
            cf_done_reg <= action == isotp_pkg::ACT_CF_DONE;
            size_reg    <= cf_size;
            if (action == isotp_pkg::ACT_FF) begin
                wbase_reg  <= '0;
                nbytes_reg <= isotp_pkg::FF_HEAD;
            end else begin
                wbase_reg  <= cf_off[AW-1:0];
                nbytes_reg <= cf_n;
            end
            if (action == isotp_pkg::ACT_FWD) begin
                kind_reg     <= isotp_pkg::KIND_FWD;
                chan_out_reg <= 8'h00;
                id_out_reg   <= frm_id_reg;
                olen_reg     <= (frm_dlc_reg > 4'd8) ? 4'd8 : frm_dlc_reg;
                odata_reg    <= frm_data_reg;
                olast_reg    <= 1'b1;
            end else begin
                kind_reg     <= isotp_pkg::KIND_CHUNK;
                chan_out_reg <= chan_reg[hit_idx];
                id_out_reg   <= '0;
                olen_reg     <= (sf_total > 4'd8) ? 4'd8 : sf_total;
                odata_reg    <= sf_chunk0;
                olast_reg    <= sf_total <= 4'd8;
            end
        end
        if (cmd.wr) begin
            j_reg <= j_reg + 4'd1;
            if (wr_last) begin
                if (mode_ff_reg) begin
                    kind_reg     <= isotp_pkg::KIND_FC;
                    chan_out_reg <= chan_reg[hit_reg];
                    id_out_reg   <= fc_txid & isotp_pkg::ID_MASK;
                    olen_reg     <= fc_dlc;
                    odata_reg    <= fc_data;
                    olast_reg    <= 1'b1;
                end else begin
                    kind_reg     <= isotp_pkg::KIND_CHUNK;
                    id_out_reg   <= '0;
                    odata_reg    <= '0;
                    olast_reg    <= 1'b0;
                    pos_reg      <= '0;
                    k_reg        <= '0;
                end
            end
        end
        if (cmd.sf_next) begin
            olen_reg  <= len_reg - 4'd8;
            odata_reg <= sf_chunk1;
            olast_reg <= 1'b1;
        end
        if (cmd.capture) begin
            odata_reg[8*(7-k_reg) +: 8] <= ram_rdata;
            olen_reg  <= {1'b0, k_reg} + 4'd1;
            olast_reg <= pos_end;
            pos_reg   <= pos_reg + CW'(1);
            k_reg     <= k_reg + 3'd1;
        end
        if (cmd.chunk_next) begin
            odata_reg <= '0;
            k_reg     <= '0;
        end
    end

    assign st.action     = action;
    assign st.wr_last    = wr_last;
    assign st.mode_ff    = mode_ff_reg;
    assign st.cf_done    = cf_done_reg;
    assign st.chunk_full = k_reg == 3'd7 || pos_end;
    assign st.out_last   = olast_reg;

    assign m_kind       = kind_reg;
    assign m_channel    = chan_out_reg;
    assign m_out_id     = id_out_reg;
    assign m_out_length = olen_reg;
    assign m_out_data   = odata_reg;
    assign m_last       = olast_reg;

endmodule

// File: src/isotp_receive_reassembler.sv
// ISO-TP receive reassembler top level: isotp_ctrl sequencer plus isotp_dp datapath.
// Depends on isotp_pkg, isotp_ctrl, isotp_dp (and isotp_ram through isotp_dp).
//
// One item at a time. Clear and load commands are applied as they are accepted. A
// frame is matched against the pair table in the decode state, then: a forwarded
// frame or single frame shows its result on the next cycle (two chunks at most for a
// single frame); a first frame writes its 10 header bytes into the buffer RAM one per
// cycle, then offers the flow-control frame; a consecutive frame writes its 1 to 7
// bytes one per cycle; a rejected frame is dropped. On completion the message is read
// back from the single-port-read buffer RAM, each byte through a read-address and a
// read-data state, each chunk of up to 8 bytes then held until taken.
module isotp_receive_reassembler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [1:0]  s_pair_index,
    input  logic [31:0] s_pair_tx_id,
    input  logic [7:0]  s_pair_tx_ext,
    input  logic [7:0]  s_pair_tx_pad,
    input  logic [31:0] s_pair_rx_id,
    input  logic [7:0]  s_pair_rx_ext,
    input  logic [7:0]  s_pair_channel,
    input  logic [31:0] s_frame_id,
    input  logic [3:0]  s_frame_dlc,
    input  logic [63:0] s_frame_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_channel,
    output logic [31:0] m_out_id,
    output logic [3:0]  m_out_length,
    output logic [63:0] m_out_data,
    output logic        m_last
);

    isotp_pkg::ctrl_cmd_t cmd;
    isotp_pkg::dp_stat_t  st;

    isotp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .m_ready   (m_ready),
        .st        (st),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .cmd       (cmd)
    );

    isotp_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .st             (st),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_command      (s_command),
        .s_pair_index   (s_pair_index),
        .s_pair_tx_id   (s_pair_tx_id),
        .s_pair_tx_ext  (s_pair_tx_ext),
        .s_pair_tx_pad  (s_pair_tx_pad),
        .s_pair_rx_id   (s_pair_rx_id),
        .s_pair_rx_ext  (s_pair_rx_ext),
        .s_pair_channel (s_pair_channel),
        .s_frame_id     (s_frame_id),
        .s_frame_dlc    (s_frame_dlc),
        .s_frame_data   (s_frame_data),
        .m_kind         (m_kind),
        .m_channel      (m_channel),
        .m_out_id       (m_out_id),
        .m_out_length   (m_out_length),
        .m_out_data     (m_out_data),
        .m_last         (m_last)
    );

endmodule

// File: sim/tb.sv
// Self-checking testbench for isotp_receive_reassembler: random and directed traffic
// against a built-in predictor of pair matching, flow control and message reassembly.
// Depends on isotp_pkg and the RTL under src/.
`timescale 1ns / 1ps

module tb;
    import isotp_pkg::*;

    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int         CYCLE_LIMIT  = 1000000;
    localparam int         SETTLE       = 64;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  idx;
        logic [31:0] tx_id;
        logic [7:0]  tx_ext;
        logic [7:0]  tx_pad;
        logic [31:0] rx_id;
        logic [7:0]  rx_ext;
        logic [7:0]  chan;
        logic [31:0] fid;
        logic [3:0]  dlc;
        logic [63:0] fdata;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  chan;
        logic [31:0] id;
        logic [3:0]  len;
        logic [63:0] data;
        logic        last;
    } rsp_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_kind;
    logic [7:0]  m_channel;
    logic [31:0] m_out_id;
    logic [3:0]  m_out_length;
    logic [63:0] m_out_data;
    logic        m_last;
    req_t        cur;

    isotp_receive_reassembler dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_command(cur.cmd), .s_pair_index(cur.idx),
        .s_pair_tx_id(cur.tx_id), .s_pair_tx_ext(cur.tx_ext), .s_pair_tx_pad(cur.tx_pad),
        .s_pair_rx_id(cur.rx_id), .s_pair_rx_ext(cur.rx_ext), .s_pair_channel(cur.chan),
        .s_frame_id(cur.fid), .s_frame_dlc(cur.dlc), .s_frame_data(cur.fdata),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_kind(m_kind), .m_channel(m_channel), .m_out_id(m_out_id),
        .m_out_length(m_out_length), .m_out_data(m_out_data), .m_last(m_last)
    );

    req_t pend_q[$];
    rsp_t rsp_q[$];
    int   s_idle_pct, m_idle_pct;
    int   errors, cycles, n_in, n_out, n_msg;
    bit   s_done;

    // predictor state
    logic [7:0]  p_bs, p_st;
    logic        p_valid [PAIRS];
    logic [31:0] p_tx_id [PAIRS];
    logic [7:0]  p_tx_ext [PAIRS];
    logic [7:0]  p_tx_pad [PAIRS];
    logic [7:0]  p_chan [PAIRS];
    logic [31:0] p_rx_id [PAIRS];
    logic [7:0]  p_rx_ext [PAIRS];
    logic [7:0]  p_buf [PAIRS][BUFFER_BYTES];
    int          p_fill [PAIRS];
    int          p_size [PAIRS];
    logic [3:0]  p_seq [PAIRS];
    logic [7:0]  stage [BUFFER_BYTES + 8];

    // generator view of the pair table
    logic        g_valid [PAIRS];
    logic [31:0] g_rx_id [PAIRS];
    logic [7:0]  g_rx_ext [PAIRS];

    function automatic logic [7:0] get_byte(logic [63:0] d, int k);
        return d[63 - 8 * k -: 8];
    endfunction

    function automatic logic [63:0] set_byte(logic [63:0] d, int k, logic [7:0] v);
        logic [63:0] r;
        r = d;
        r[63 - 8 * k -: 8] = v;
        return r;
    endfunction

    function automatic logic [63:0] pack_stage(int start, int n);
        logic [63:0] d;
        d = '0;
        for (int k = 0; k < 8; k++)
            d = {d[55:0], (k < n) ? stage[start + k] : 8'h00};
        return d;
    endfunction

    function automatic void stage_id(logic [31:0] id);
        for (int k = 0; k < 4; k++)
            stage[k] = id[31 - 8 * k -: 8];
    endfunction

    function automatic void emit_chunks(int total, logic [7:0] ch);
        rsp_t r;
        int pos, take;
        pos = 0;
        while (pos < total) begin
            take = (total - pos > 8) ? 8 : total - pos;
            r = '{KIND_CHUNK, ch, 32'h0, take[3:0], pack_stage(pos, take), pos + take >= total};
            rsp_q.push_back(r);
            pos += take;
        end
        n_msg++;
    endfunction

    function automatic void handle_matched(int i, logic [31:0] id, logic [63:0] d);
        int p, cap, rem, n, start, len;
        logic [7:0] pb;
        rsp_t r;
        p = p_rx_id[i][EXT_ADDR_BIT];
        pb = get_byte(d, p);
        case (pb[7:4])
            PCI_SF: begin
                if (pb > 7 - p) return;
                for (int k = 0; k < 12; k++) stage[k] = 8'h00;
                stage_id(id);
                stage[4] = get_byte(d, 0);
                for (int j = 0; j < 7 - p; j++) stage[4 + p + j] = get_byte(d, p + 1 + j);
                emit_chunks(pb + p + 4, p_chan[i]);
            end
            PCI_FF: begin
                len = get_byte(d, p + 1);
                if (pb != PCI_FF_BYTE || len + p + 4 > BUFFER_BYTES) return;
                p_fill[i] = FF_HEAD;
                p_size[i] = len + p + 4;
                p_seq[i] = 4'd1;
                for (int k = 0; k < 4; k++) p_buf[i][k] = id[31 - 8 * k -: 8];
                p_buf[i][4] = get_byte(d, 0);
                for (int j = 0; j < 6 - p; j++) p_buf[i][4 + p + j] = get_byte(d, p + 2 + j);
                stage[0] = p_tx_ext[i];
                stage[1] = PCI_FC_CTS;
                stage[2] = p_bs;
                stage[3] = p_st;
                for (int k = 4; k < 9; k++) stage[k] = p_tx_pad[i];
                start = 1;
                n = 3;
                if (p_tx_id[i][EXT_ADDR_BIT]) begin
                    start = 0;
                    n = 4;
                end
                if (p_tx_id[i][PAD_BIT]) n = 8;
                r = '{KIND_FC, p_chan[i], p_tx_id[i] & ID_MASK, n[3:0], pack_stage(start, n),
                      1'b1};
                rsp_q.push_back(r);
            end
            PCI_CF: begin
                cap = 7 - p;
                if (p_fill[i] >= p_size[i] || pb[3:0] != p_seq[i]) return;
                p_seq[i] = p_seq[i] + 4'd1;
                rem = p_size[i] - p_fill[i];
                n = (rem < cap) ? rem : cap;
                for (int j = 0; j < n; j++)
                    if (p_fill[i] + j < BUFFER_BYTES)
                        p_buf[i][p_fill[i] + j] = get_byte(d, p + 1 + j);
                p_fill[i] += n;
                if (rem <= cap) begin
                    for (int k = 0; k < p_size[i]; k++) stage[k] = p_buf[i][k];
                    emit_chunks(p_size[i], p_chan[i]);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void isotp_predict(req_t q);
        rsp_t r;
        case (q.cmd)
            CMD_CLEAR: begin
                for (int i = 0; i < PAIRS; i++) begin
                    p_valid[i] = 0;
                    p_tx_id[i] = '0; p_tx_ext[i] = '0; p_tx_pad[i] = '0; p_chan[i] = '0;
                    p_rx_id[i] = '0; p_rx_ext[i] = '0;
                end
            end
            CMD_LOAD: begin
                if (q.idx < PAIRS) begin
                    p_valid[q.idx] = 1;
                    p_tx_id[q.idx] = q.tx_id;
                    p_tx_ext[q.idx] = q.tx_ext;
                    p_tx_pad[q.idx] = q.tx_pad;
                    p_chan[q.idx] = q.chan;
                    p_rx_id[q.idx] = q.rx_id;
                    p_rx_ext[q.idx] = q.rx_ext;
                end
            end
            CMD_FRAME: begin
                for (int i = 0; i < PAIRS; i++) begin
                    if (p_valid[i] && (q.fid & ID_MASK) == (p_rx_id[i] & ID_MASK) &&
                        (!p_rx_id[i][EXT_ADDR_BIT] || p_rx_ext[i] == get_byte(q.fdata, 0))) begin
                        handle_matched(i, q.fid, q.fdata);
                        return;
                    end
                end
                r = '{KIND_FWD, 8'h00, q.fid, (q.dlc > 8) ? 4'd8 : q.dlc, q.fdata, 1'b1};
                rsp_q.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // stimulus builders
    function automatic req_t blank(logic [1:0] c);
        req_t q;
        q = '0;
        q.cmd = c;
        q.idx = $urandom;
        q.fid = $urandom;
        q.dlc = $urandom;
        q.fdata = {$urandom, $urandom};
        return q;
    endfunction

    function automatic void push_load(int s, logic [31:0] rx, logic [7:0] rxe, logic [31:0] tx);
        req_t q;
        q = blank(CMD_LOAD);
        q.idx = s;
        q.rx_id = rx;
        q.rx_ext = rxe;
        q.tx_id = tx;
        q.tx_ext = $urandom;
        q.tx_pad = $urandom;
        q.chan = $urandom;
        pend_q.push_back(q);
        g_valid[s] = 1;
        g_rx_id[s] = rx;
        g_rx_ext[s] = rxe;
    endfunction

    function automatic void push_clear();
        pend_q.push_back(blank(CMD_CLEAR));
        for (int i = 0; i < PAIRS; i++) g_valid[i] = 0;
    endfunction

    function automatic void push_frame(logic [31:0] id, logic [63:0] d);
        req_t q;
        q = blank(CMD_FRAME);
        q.fid = id;
        q.fdata = d;
        pend_q.push_back(q);
    endfunction

    function automatic logic [31:0] slot_id(int s);
        return (g_rx_id[s] & ID_MASK) | ($urandom & 32'h6000_0000);
    endfunction

    function automatic logic [63:0] slot_data(int s);
        logic [63:0] d;
        d = {$urandom, $urandom};
        if (g_rx_id[s][EXT_ADDR_BIT]) d = set_byte(d, 0, g_rx_ext[s]);
        return d;
    endfunction

    function automatic void gen_message(int s);
        int p, len, size, ncf, r;
        logic [63:0] d;
        p = g_rx_id[s][EXT_ADDR_BIT];
        d = slot_data(s);
        r = $urandom_range(0, 99);
        if (r < 30) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(8 - p, 15) : $urandom_range(0, 7 - p);
            push_frame(slot_id(s), set_byte(d, p, len));
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 85) len = $urandom_range(0, 40);
        else if (r < 95) len = $urandom_range(41, 252 - p);
        else len = $urandom_range(253 - p, 255);
        d = set_byte(d, p + 1, len);
        if ($urandom_range(0, 19) == 0) begin
            push_frame(slot_id(s), set_byte(d, p, PCI_FF_BYTE | $urandom_range(1, 15)));
            return;
        end
        push_frame(slot_id(s), set_byte(d, p, PCI_FF_BYTE));
        size = len + p + 4;
        if (size > BUFFER_BYTES) return;
        ncf = (size > FF_HEAD) ? (size - FF_HEAD + 6 - p) / (7 - p) : 0;
        for (int k = 1; k <= ncf; k++) begin
            if ($urandom_range(0, 14) == 0)
                push_frame(slot_id(s), set_byte(slot_data(s), p, {PCI_CF, 4'(k + 3)}));
            push_frame(slot_id(s), set_byte(slot_data(s), p, {PCI_CF, 4'(k)}));
        end
    endfunction

    function automatic void gen_random(int quota);
        int base, r, s;
        base = pend_q.size();
        while (pend_q.size() - base < quota) begin
            r = $urandom_range(0, 99);
            s = $urandom_range(0, PAIRS - 1);
            if (r < 8) push_load(s, $urandom, $urandom, $urandom);
            else if (r < 11) push_clear();
            else if (r < 14) pend_q.push_back(blank(CMD_RESERVED));
            else if (r < 22) push_frame($urandom, {$urandom, $urandom});
            else if (r < 28 && g_valid[s]) push_frame(slot_id(s), slot_data(s));
            else begin
                if (!g_valid[s])
                    push_load(s, $urandom & 32'hDFFF_FFFF, $urandom, $urandom);
                gen_message(s);
            end
        end
    endfunction

    task automatic drain();
        while (pend_q.size() != 0 || s_valid || rsp_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [7:0] bs, logic [7:0] st);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_BLOCK_SIZE;
        cfg_wdata <= bs;
        @(negedge aclk);
        cfg_index <= CFG_SEP_TIME;
        cfg_wdata <= st;
        @(negedge aclk);
        cfg_we <= 1'b0;
        p_bs = bs;
        p_st = st;
    endtask

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_done) begin
                s_done = 0;
                if (pend_q.size() != 0 && $urandom_range(0, 99) >= s_idle_pct) begin
                    cur <= pend_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(0, 99) >= m_idle_pct);
        end
    end

    always @(posedge aclk) begin
        rsp_t e;
        if (aresetn) begin
            cycles++;
            if (s_valid && s_ready) begin
                isotp_predict(cur);
                s_done = 1;
                n_in++;
            end
            if (m_valid && m_ready) begin
                n_out++;
                if (rsp_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transfer kind=%0d id=%h data=%h", $time,
                             m_kind, m_out_id, m_out_data);
                end else begin
                    e = rsp_q.pop_front();
                    if (e != {m_kind, m_channel, m_out_id, m_out_length, m_out_data, m_last}) begin
                        errors++;
                        $display("%0t: exp kind=%0d ch=%h id=%h len=%0d data=%h last=%b", $time,
                                 e.kind, e.chan, e.id, e.len, e.data, e.last);
                        $display("%0t: got kind=%0d ch=%h id=%h len=%0d data=%h last=%b", $time,
                                 m_kind, m_channel, m_out_id, m_out_length, m_out_data, m_last);
                    end
                end
            end
            if (cycles > CYCLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] bs_set [6];
        logic [7:0] st_set [6];
        logic [63:0] d;
        bs_set = '{8'h00, 8'hFF, 8'h5A, 8'h00, 8'hFF, 8'h00};
        st_set = '{8'hFF, 8'h00, 8'hA5, 8'h00, 8'hFF, 8'h00};
        s_valid = 0;
        s_done = 0;
        m_ready = 0;
        cur = '0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_wdata = 0;
        errors = 0;
        cycles = 0;
        n_in = 0;
        n_out = 0;
        n_msg = 0;
        p_bs = 0;
        p_st = 0;
        for (int i = 0; i < PAIRS; i++) begin
            p_valid[i] = 0; p_tx_id[i] = 0; p_tx_ext[i] = 0; p_tx_pad[i] = 0; p_chan[i] = 0;
            p_rx_id[i] = 0; p_rx_ext[i] = 0; p_fill[i] = 0; p_size[i] = 0; p_seq[i] = 0;
            g_valid[i] = 0; g_rx_id[i] = 0; g_rx_ext[i] = 0;
            for (int k = 0; k < BUFFER_BYTES; k++) p_buf[i][k] = 0;
        end
        aresetn = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        for (int ph = 0; ph < 6; ph++) begin
            s_idle_pct = (ph < 2) ? 28 : (ph < 4) ? 56 : 0;
            m_idle_pct = (ph < 2) ? 56 : (ph < 4) ? 28 : 0;
            drain();
            write_cfg(bs_set[ph], st_set[ph]);
            if (ph == 0) begin
                // directed: both address styles, every PCI type and the reject paths
                push_clear();
                push_load(0, 32'h0000_07E0, 8'h00, 32'h2000_07E8);
                push_load(1, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
                push_load(3, 32'h8000_0000, 8'h00, 32'h4000_0000);
                pend_q.push_back(blank(CMD_RESERVED));
                push_frame(32'h0000_07E0, 64'h00FF_FFFF_FFFF_FFFF);
                push_frame(32'h6000_07E0, 64'h0711_2233_4455_6677);
                push_frame(32'h0000_07E0, 64'h0811_2233_4455_6677);
                push_frame(32'hFFFF_FFFF, 64'hFF06_0102_0304_0506);
                push_frame(32'hFFFF_FFFF, 64'hFF10_FC00_0000_0000);
                push_frame(32'h0000_07E0, 64'h1005_AAAA_AAAA_AAAA);
                push_frame(32'h0000_07E0, 64'h1014_0102_0304_0506);
                push_frame(32'h0000_07E0, 64'h2207_0809_0A0B_0C0D);
                push_frame(32'h0000_07E0, 64'h2107_0809_0A0B_0C0D);
                push_frame(32'h0000_07E0, 64'h220E_0F10_1112_1314);
                push_frame(32'h0000_07E0, 64'h2100_0000_0000_0000);
                push_frame(32'h0000_07E0, 64'h3000_0000_0000_0000);
                push_frame(32'h0000_07E0, 64'h1114_0000_0000_0000);
                push_frame(32'h8000_0000, 64'h0300_0000_0000_0000);
                push_frame(32'h1234_5678, 64'hFFFF_FFFF_FFFF_FFFF);
                pend_q[pend_q.size() - 1].dlc = 4'hF;
                push_frame(32'h1234_5678, 64'h0);
                pend_q[pend_q.size() - 1].dlc = 4'h0;
                // the longest message the buffer holds, sent one consecutive frame short of complete
                d = 64'h10FC_0000_0000_0000;
                push_frame(32'h0000_07E0, d);
                for (int k = 1; k <= 35; k++)
                    push_frame(32'h0000_07E0, {PCI_CF, 4'(k), 56'(k)});
            end
            gen_random(20);
            if (ph == 2) drain();
            gen_random(20);
        end
        drain();
        $display("Covered %0d accepted items and %0d result transfers (%0d messages),",
                 n_in, n_out, n_msg);
        $display("over six register settings and three handshake idling patterns.");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
